[rtl/tmat_pkg.sv]
// shared types, constants and helpers of the adaptive tile threshold core
package tmat_pkg;

    localparam int PIX_W      = 8;
    localparam int SIZE_CFG_W = 12;
    localparam int CONTRAST_W = 9;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int TILE_RING  = 4;
    localparam int FIFO_DEPTH = 8;

    localparam logic [SIZE_CFG_W-1:0] WIDTH_RESET    = 12'd640;
    localparam logic [SIZE_CFG_W-1:0] HEIGHT_RESET   = 12'd480;
    localparam logic [CONTRAST_W-1:0] CONTRAST_RESET = 9'd5;

    localparam logic [PIX_W-1:0] LEVEL_BLACK     = 8'd0;
    localparam logic [PIX_W-1:0] LEVEL_WHITE     = 8'd255;
    localparam logic [PIX_W-1:0] LEVEL_UNDECIDED = 8'd127;

    localparam logic FUNC_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MIN_CONTRAST = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
    } span_t;

    typedef struct packed {
        logic valid;
        logic row_start;
        logic last;
    } launch_t;

    typedef struct packed {
        logic             frame_end;
        logic [PIX_W-1:0] level;
    } result_t;

    function automatic span_t span_merge(span_t a, span_t b);
        span_t r;
        r.lo = (b.lo < a.lo) ? b.lo : a.lo;
        r.hi = (b.hi > a.hi) ? b.hi : a.hi;
        return r;
    endfunction

endpackage

[rtl/tmat_ram.sv]
// generic single write, single read ram with registered read data
module tmat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word when the same entry is written in that cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/tmat_ingest.sv]
// tile min/max accumulation on the input side, partial tile rows in a scratch ram
module tmat_ingest #(
    parameter int TX_W = 9
) (
    input  logic                              aclk,
    input  logic                              pix_en,
    input  logic [1:0]                        col_lo,
    input  logic [1:0]                        row_lo,
    input  logic [TX_W-1:0]                   tc,
    input  logic [1:0]                        tile_slot,
    input  logic                              col_last,
    input  logic                              row_last,
    input  logic [tmat_pkg::PIX_W-1:0]        pixel,
    output logic [tmat_pkg::TILE_RING-1:0]    tile_we,
    output logic [TX_W-1:0]                   tile_waddr,
    output tmat_pkg::span_t                   tile_wdata
);

    localparam int SCR_DEPTH = 1 << TX_W;

    tmat_pkg::span_t acc_reg;
    tmat_pkg::span_t last_wr_reg;
    tmat_pkg::span_t pspan, cur, base, full, scr_rd_data;
    logic grp_first, grp_last, row_first, row_final;
    logic scr_rd_en, scr_we;

    always_comb begin
        grp_first = (col_lo == 2'd0);
        grp_last  = (col_lo == 2'd3) || col_last;
        row_first = (row_lo == 2'd0);
        row_final = (row_lo == 2'd3) || row_last;
        pspan.lo  = pixel;
        pspan.hi  = pixel;
        cur  = grp_first ? pspan : tmat_pkg::span_merge(acc_reg, pspan);
        // a one pixel wide frame reads back what it wrote the pixel before
        base = grp_first ? last_wr_reg : scr_rd_data;
        full = row_first ? cur : tmat_pkg::span_merge(cur, base);
        scr_rd_en = pix_en && grp_first;
        scr_we    = pix_en && grp_last && !row_final;
        tile_we   = (pix_en && grp_last && row_final) ?
                    (tmat_pkg::TILE_RING'(1) << tile_slot) : '0;
        tile_waddr = tc;
        tile_wdata = full;
    end

    always_ff @(posedge aclk) begin
        if (pix_en) begin
            acc_reg <= cur;
        end
        if (scr_we) begin
            last_wr_reg <= full;
        end
    end

    tmat_ram #(
        .WIDTH ($bits(tmat_pkg::span_t)),
        .DEPTH (SCR_DEPTH)
    ) u_scratch (
        .aclk    (aclk),
        .wr_en   (scr_we),
        .wr_addr (tc),
        .wr_data (full),
        .rd_en   (scr_rd_en),
        .rd_addr (tc),
        .rd_data (scr_rd_data)
    );

endmodule

[rtl/tmat_eval.sv]
// result pipeline: buffer reads, 3x3 tile neighborhood, threshold decision
module tmat_eval #(
    parameter int COL_W  = 11,
    parameter int SLOT_W = 4,
    parameter int TX_W   = 9
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tmat_pkg::launch_t                    launch,
    input  logic [COL_W-1:0]                     l_col,
    input  logic [SLOT_W-1:0]                    l_slot,
    input  logic [TX_W-1:0]                      l_tx,
    input  logic [TX_W-1:0]                      l_txn,
    input  logic [1:0]                           l_tr_m,
    input  logic [1:0]                           l_tr_c,
    input  logic [1:0]                           l_tr_p,
    input  logic [tmat_pkg::CONTRAST_W-1:0]      min_contrast,
    output logic                                 rd_en,
    output logic [SLOT_W+COL_W-1:0]              pix_rd_addr,
    output logic [TX_W-1:0]                      tile_rd_addr_a,
    output logic [TX_W-1:0]                      tile_rd_addr_b,
    input  logic [tmat_pkg::PIX_W-1:0]           pix_rd_data,
    input  tmat_pkg::span_t                      tile_rd_a [tmat_pkg::TILE_RING],
    input  tmat_pkg::span_t                      tile_rd_b [tmat_pkg::TILE_RING],
    output logic                                 res_valid,
    output tmat_pkg::result_t                    res
);

    tmat_pkg::launch_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [TX_W-1:0]   s1_tx_reg, s1_txn_reg, s2_tx_reg, s3_tx_reg, last_tx_reg;
    logic [1:0]        s1_trm_reg, s1_trc_reg, s1_trp_reg;
    logic [1:0]        s2_trm_reg, s2_trc_reg, s2_trp_reg;
    tmat_pkg::span_t   s3_a_reg, s3_b_reg, s4_span_reg, left_reg, last_a_reg;
    logic [tmat_pkg::PIX_W-1:0] s3_pix_reg, s4_pix_reg;
    tmat_pkg::span_t   col_a, col_b, left, nb;
    logic [tmat_pkg::PIX_W-1:0] diff;
    logic [tmat_pkg::PIX_W:0]   thr;
    logic [tmat_pkg::PIX_W-1:0] level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end else begin
            s1_ctl_reg <= launch;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    // read stage addresses
    always_comb begin
        rd_en          = s1_ctl_reg.valid;
        pix_rd_addr    = {s1_slot_reg, s1_col_reg};
        tile_rd_addr_a = s1_tx_reg;
        tile_rd_addr_b = s1_txn_reg;
    end

    // vertical min/max over the three clamped tile rows
    always_comb begin
        col_a = tmat_pkg::span_merge(tmat_pkg::span_merge(tile_rd_a[s2_trm_reg],
                    tile_rd_a[s2_trc_reg]), tile_rd_a[s2_trp_reg]);
        col_b = tmat_pkg::span_merge(tmat_pkg::span_merge(tile_rd_b[s2_trm_reg],
                    tile_rd_b[s2_trc_reg]), tile_rd_b[s2_trp_reg]);
    end

    // left column comes from the previous result once the tile column advances
    always_comb begin
        if (s3_ctl_reg.row_start) begin
            left = s3_a_reg;
        end else if (s3_tx_reg != last_tx_reg) begin
            left = last_a_reg;
        end else begin
            left = left_reg;
        end
        nb = tmat_pkg::span_merge(tmat_pkg::span_merge(left, s3_a_reg), s3_b_reg);
    end

    always_comb begin
        diff = (s4_span_reg.hi >= s4_span_reg.lo) ? (s4_span_reg.hi - s4_span_reg.lo) : '0;
        thr  = {1'b0, s4_span_reg.lo} + {2'b00, diff[tmat_pkg::PIX_W-1:1]};
        if ({1'b0, diff} < min_contrast) begin
            level = tmat_pkg::LEVEL_UNDECIDED;
        end else if ({1'b0, s4_pix_reg} > thr) begin
            level = tmat_pkg::LEVEL_WHITE;
        end else begin
            level = tmat_pkg::LEVEL_BLACK;
        end
        res_valid     = s4_ctl_reg.valid;
        res.level     = level;
        res.frame_end = s4_ctl_reg.last;
    end

    always_ff @(posedge aclk) begin
        s1_col_reg  <= l_col;
        s1_slot_reg <= l_slot;
        s1_tx_reg   <= l_tx;
        s1_txn_reg  <= l_txn;
        s1_trm_reg  <= l_tr_m;
        s1_trc_reg  <= l_tr_c;
        s1_trp_reg  <= l_tr_p;
        s2_tx_reg   <= s1_tx_reg;
        s2_trm_reg  <= s1_trm_reg;
        s2_trc_reg  <= s1_trc_reg;
        s2_trp_reg  <= s1_trp_reg;
        s3_tx_reg   <= s2_tx_reg;
        s3_a_reg    <= col_a;
        s3_b_reg    <= col_b;
        s3_pix_reg  <= pix_rd_data;
        s4_span_reg <= nb;
        s4_pix_reg  <= s3_pix_reg;
        if (s3_ctl_reg.valid) begin
            left_reg    <= left;
            last_tx_reg <= s3_tx_reg;
            last_a_reg  <= s3_a_reg;
        end
    end

endmodule

[rtl/tmat_ofifo.sv]
// small result queue in front of the master channel
module tmat_ofifo #(
    parameter int DEPTH = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tmat_pkg::result_t push_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tmat_pkg::result_t m_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tmat_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/tile_minmax_adaptive_threshold_core.sv]
// adaptive 4x4 tile min/max threshold core: one pixel transfer per clock while ready is high, 3x3 tile window
// throughput: one input transfer per clock; ready drops only while 8 results are queued or in flight
// result path: a result made due by a transfer passes the ram read stage, the row/column window
//   stages and the output queue
// reset: synchronous active-low aresetn clears positions, queue and config to 640 x 480, contrast 5
// pixel and tile buffers are not cleared; entries are only read after they were written
module tile_minmax_adaptive_threshold_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int ROW_RING   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel
    input  logic [0:0]                        s_tuser,   // [0] func (1 = drain)
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] level
    output logic                              m_tlast,   // frame_end
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [tmat_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [tmat_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WD_W       = $clog2(MAX_WIDTH + 1);
    localparam int HD_W       = $clog2(MAX_HEIGHT + 1);
    localparam int NW         = HD_W + 2;
    localparam int TX_W       = (COL_W > 2) ? COL_W - 2 : 1;
    localparam int SLOT_W     = $clog2(ROW_RING);
    localparam int PIX_DEPTH  = ROW_RING << COL_W;
    localparam int TILE_DEPTH = 1 << TX_W;
    localparam int OCC_W      = $clog2(tmat_pkg::FIFO_DEPTH + 1);

    // configuration registers
    logic [tmat_pkg::SIZE_CFG_W-1:0] width_cfg_reg, height_cfg_reg;
    logic [tmat_pkg::CONTRAST_W-1:0] contrast_reg;
    logic size_write;

    // raster positions
    logic [COL_W-1:0]  in_col_reg,  in_col_next,  out_col_reg,  out_col_next;
    logic [ROW_W-1:0]  in_row_reg,  in_row_next,  out_row_reg,  out_row_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic              frame_rcv_reg, frame_rcv_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;

    // effective frame geometry
    logic [WD_W-1:0] w_dim, tw, tw_raw;
    logic [HD_W-1:0] h_dim, th, th_raw;

    logic s_xfer, m_xfer, take_pix, pix_en, launch_due;
    logic col_last_in, row_last_in, out_col_last, out_last;
    logic [WD_W-1:0] in_tc_w, out_tc_w, tx_w, txn_w;
    logic [HD_W-1:0] in_tr_w, out_tr_w, ty_w, tym_w, typ_w;
    logic [NW-1:0]   need_a, need_b, need, h_m1;

    tmat_pkg::launch_t launch;
    tmat_pkg::result_t fifo_in, fifo_out;
    logic              res_valid;

    // memory ports
    logic [tmat_pkg::TILE_RING-1:0] tile_we;
    logic [TX_W-1:0]                tile_waddr, tile_rd_addr_a, tile_rd_addr_b;
    tmat_pkg::span_t                tile_wdata;
    tmat_pkg::span_t                tile_rd_a [tmat_pkg::TILE_RING];
    tmat_pkg::span_t                tile_rd_b [tmat_pkg::TILE_RING];
    logic                           ev_rd_en;
    logic [SLOT_W+COL_W-1:0]        pix_rd_addr;
    logic [tmat_pkg::PIX_W-1:0]     pix_rd_data;

    // width and height clamped to 1..MAX, grid is max(1, size/4) tiles
    always_comb begin
        if (width_cfg_reg == '0) begin
            w_dim = WD_W'(1);
        end else if (32'(width_cfg_reg) > MAX_WIDTH) begin
            w_dim = WD_W'(MAX_WIDTH);
        end else begin
            w_dim = WD_W'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_dim = HD_W'(1);
        end else if (32'(height_cfg_reg) > MAX_HEIGHT) begin
            h_dim = HD_W'(MAX_HEIGHT);
        end else begin
            h_dim = HD_W'(height_cfg_reg);
        end
        tw_raw = w_dim >> 2;
        th_raw = h_dim >> 2;
        tw = (tw_raw == '0) ? WD_W'(1) : tw_raw;
        th = (th_raw == '0) ? HD_W'(1) : th_raw;
    end

    assign size_write = cfg_wr_en &&
        ((tmat_pkg::cfg_index_t'(cfg_wr_index) == tmat_pkg::CFG_FRAME_WIDTH) ||
         (tmat_pkg::cfg_index_t'(cfg_wr_index) == tmat_pkg::CFG_FRAME_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= tmat_pkg::WIDTH_RESET;
            height_cfg_reg <= tmat_pkg::HEIGHT_RESET;
            contrast_reg   <= tmat_pkg::CONTRAST_RESET;
        end else if (cfg_wr_en) begin
            case (tmat_pkg::cfg_index_t'(cfg_wr_index))
                tmat_pkg::CFG_FRAME_WIDTH: begin
                    width_cfg_reg <= cfg_wr_data;
                end
                tmat_pkg::CFG_FRAME_HEIGHT: begin
                    height_cfg_reg <= cfg_wr_data;
                end
                tmat_pkg::CFG_MIN_CONTRAST: begin
                    contrast_reg <= cfg_wr_data[tmat_pkg::CONTRAST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // handshakes; ready holds while queue plus pipeline can take one more result
    assign s_tready = (occ_reg < OCC_W'(tmat_pkg::FIFO_DEPTH));
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;
    // a pixel after the frame is complete counts as a drain
    assign take_pix = s_xfer && (s_tuser[0] != tmat_pkg::FUNC_DRAIN) && !frame_rcv_reg;

    // input side position and tile membership
    always_comb begin
        col_last_in = (WD_W'(in_col_reg) == w_dim - WD_W'(1));
        row_last_in = (HD_W'(in_row_reg) == h_dim - HD_W'(1));
        in_tc_w     = WD_W'(in_col_reg) >> 2;
        in_tr_w     = HD_W'(in_row_reg) >> 2;
        pix_en      = take_pix && (in_tc_w < tw) && (in_tr_w < th);
    end

    // output side tile coordinates, clamped to the grid
    always_comb begin
        out_tc_w = WD_W'(out_col_reg) >> 2;
        out_tr_w = HD_W'(out_row_reg) >> 2;
        tx_w  = (out_tc_w >= tw) ? tw - WD_W'(1) : out_tc_w;
        ty_w  = (out_tr_w >= th) ? th - HD_W'(1) : out_tr_w;
        txn_w = (tx_w + WD_W'(1) < tw) ? tx_w + WD_W'(1) : tw - WD_W'(1);
        tym_w = (ty_w == '0) ? '0 : ty_w - HD_W'(1);
        typ_w = (ty_w + HD_W'(1) < th) ? ty_w + HD_W'(1) : th - HD_W'(1);
        out_col_last = (WD_W'(out_col_reg) == w_dim - WD_W'(1));
        out_last     = out_col_last && (HD_W'(out_row_reg) == h_dim - HD_W'(1));
    end

    // position update and readiness of the next result
    always_comb begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        in_slot_next   = in_slot_reg;
        frame_rcv_next = frame_rcv_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_slot_next  = out_slot_reg;

        if (take_pix) begin
            if (col_last_in) begin
                in_col_next = '0;
                if (row_last_in) begin
                    in_row_next    = '0;
                    in_slot_next   = '0;
                    frame_rcv_next = 1'b1;
                end else begin
                    in_row_next  = in_row_reg + 1'b1;
                    in_slot_next = (in_slot_reg == SLOT_W'(ROW_RING - 1)) ? '0 :
                                   in_slot_reg + 1'b1;
                end
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
        end

        // due once the last row of the lower neighbor tile row is fully in
        h_m1   = NW'(h_dim - HD_W'(1));
        need_a = {typ_w, 2'b11};
        need_b = (need_a > h_m1) ? h_m1 : need_a;
        need   = (NW'(out_row_reg) > need_b) ? NW'(out_row_reg) : need_b;
        launch_due = s_xfer && (frame_rcv_next || (NW'(in_row_next) > need));

        if (launch_due) begin
            if (out_last) begin
                // frame wrap clears every position
                in_col_next    = '0;
                in_row_next    = '0;
                in_slot_next   = '0;
                frame_rcv_next = 1'b0;
                out_col_next   = '0;
                out_row_next   = '0;
                out_slot_next  = '0;
            end else if (out_col_last) begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 1'b1;
                out_slot_next = (out_slot_reg == SLOT_W'(ROW_RING - 1)) ? '0 :
                                out_slot_reg + 1'b1;
            end else begin
                out_col_next = out_col_reg + 1'b1;
            end
        end

        occ_next = occ_reg + OCC_W'(launch_due) - OCC_W'(m_xfer);

        launch.valid     = launch_due;
        launch.row_start = (out_col_reg == '0);
        launch.last      = out_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            frame_rcv_reg <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            occ_reg       <= '0;
        end else begin
            occ_reg <= occ_next;
            if (size_write) begin
                // a new frame size abandons the frame in progress
                in_col_reg    <= '0;
                in_row_reg    <= '0;
                in_slot_reg   <= '0;
                frame_rcv_reg <= 1'b0;
                out_col_reg   <= '0;
                out_row_reg   <= '0;
                out_slot_reg  <= '0;
            end else begin
                in_col_reg    <= in_col_next;
                in_row_reg    <= in_row_next;
                in_slot_reg   <= in_slot_next;
                frame_rcv_reg <= frame_rcv_next;
                out_col_reg   <= out_col_next;
                out_row_reg   <= out_row_next;
                out_slot_reg  <= out_slot_next;
            end
        end
    end

    // tile min/max of the incoming rows
    tmat_ingest #(
        .TX_W (TX_W)
    ) u_ingest (
        .aclk       (aclk),
        .pix_en     (pix_en),
        .col_lo     (in_col_reg[1:0]),
        .row_lo     (in_row_reg[1:0]),
        .tc         (TX_W'(in_tc_w)),
        .tile_slot  (in_tr_w[1:0]),
        .col_last   (col_last_in),
        .row_last   (row_last_in),
        .pixel      (s_tdata),
        .tile_we    (tile_we),
        .tile_waddr (tile_waddr),
        .tile_wdata (tile_wdata)
    );

    // ring of pixel rows, rows padded to a power of two
    tmat_ram #(
        .WIDTH (tmat_pkg::PIX_W),
        .DEPTH (PIX_DEPTH)
    ) u_pix_ram (
        .aclk    (aclk),
        .wr_en   (take_pix),
        .wr_addr ({in_slot_reg, in_col_reg}),
        .wr_data (s_tdata),
        .rd_en   (ev_rd_en),
        .rd_addr (pix_rd_addr),
        .rd_data (pix_rd_data)
    );

    // one ram per tile ring row, duplicated for the center and right window columns
    for (genvar g = 0; g < tmat_pkg::TILE_RING; g++) begin : g_tile
        tmat_ram #(
            .WIDTH ($bits(tmat_pkg::span_t)),
            .DEPTH (TILE_DEPTH)
        ) u_tile_a (
            .aclk    (aclk),
            .wr_en   (tile_we[g]),
            .wr_addr (tile_waddr),
            .wr_data (tile_wdata),
            .rd_en   (ev_rd_en),
            .rd_addr (tile_rd_addr_a),
            .rd_data (tile_rd_a[g])
        );
        tmat_ram #(
            .WIDTH ($bits(tmat_pkg::span_t)),
            .DEPTH (TILE_DEPTH)
        ) u_tile_b (
            .aclk    (aclk),
            .wr_en   (tile_we[g]),
            .wr_addr (tile_waddr),
            .wr_data (tile_wdata),
            .rd_en   (ev_rd_en),
            .rd_addr (tile_rd_addr_b),
            .rd_data (tile_rd_b[g])
        );
    end

    // result pipeline
    tmat_eval #(
        .COL_W  (COL_W),
        .SLOT_W (SLOT_W),
        .TX_W   (TX_W)
    ) u_eval (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .launch         (launch),
        .l_col          (out_col_reg),
        .l_slot         (out_slot_reg),
        .l_tx           (TX_W'(tx_w)),
        .l_txn          (TX_W'(txn_w)),
        .l_tr_m         (tym_w[1:0]),
        .l_tr_c         (ty_w[1:0]),
        .l_tr_p         (typ_w[1:0]),
        .min_contrast   (contrast_reg),
        .rd_en          (ev_rd_en),
        .pix_rd_addr    (pix_rd_addr),
        .tile_rd_addr_a (tile_rd_addr_a),
        .tile_rd_addr_b (tile_rd_addr_b),
        .pix_rd_data    (pix_rd_data),
        .tile_rd_a      (tile_rd_a),
        .tile_rd_b      (tile_rd_b),
        .res_valid      (res_valid),
        .res            (fifo_in)
    );

    // output queue decouples the pipeline from master stalls
    tmat_ofifo #(
        .DEPTH (tmat_pkg::FIFO_DEPTH)
    ) u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (fifo_in),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (fifo_out)
    );

    assign m_tdata = fifo_out.level;
    assign m_tlast = fifo_out.frame_end;

endmodule

[dv/tb_tile_minmax_adaptive_threshold_core.sv]
// self-checking testbench of the adaptive tile threshold core
module tb_tile_minmax_adaptive_threshold_core;
    timeunit 1ns;
    timeprecision 1ps;
    import tmat_pkg::*;

    localparam int MAX_W      = 2048;
    localparam int MAX_H      = 2048;
    localparam int LINE_RING  = 16;
    localparam int TILE_SIDE  = 4;
    localparam int TILE_COLS  = MAX_W / TILE_SIDE;
    localparam int SETTLE_CYC = 20;     // output latency plus margin
    localparam int STUCK_CYC  = 5000;   // cycles without any transfer before giving up
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;   // no register behind it

    typedef struct {
        bit         drain;
        logic [7:0] pix;
    } px_item_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic m_tlast;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    tile_minmax_adaptive_threshold_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // threshold predictor state: own copy of buffers, positions, config
    // ---------------------------------------------------------------
    logic [7:0] line_buf [LINE_RING*MAX_W];
    logic [7:0] tile_lo_buf [TILE_RING*TILE_COLS];
    logic [7:0] tile_hi_buf [TILE_RING*TILE_COLS];
    int unsigned wr_col, wr_row, rd_col, rd_row;
    bit          frame_in;          // whole frame taken in
    bit          frame_closed;      // frame_end result predicted
    logic [SIZE_CFG_W-1:0] p_width  = WIDTH_RESET;
    logic [SIZE_CFG_W-1:0] p_height = HEIGHT_RESET;
    logic [CONTRAST_W-1:0] p_contrast = CONTRAST_RESET;

    result_t   levels_due[$];       // predicted results not yet seen
    px_item_t  px_pending[$];       // items waiting for the driver
    int        errors = 0;
    int        sender_idle = 0;     // percent of cycles the sender holds off
    int        sink_stall  = 0;     // percent of cycles the receiver stalls
    int        quiet_cycles = 0;

    function automatic int unsigned fit_size(logic [SIZE_CFG_W-1:0] v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned tiles_of(int unsigned n);
        return (n / TILE_SIDE < 1) ? 1 : n / TILE_SIDE;
    endfunction

    task automatic restart_positions();
        wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0;
        frame_in = 0;
    endtask

    // one accepted input transfer: absorb the pixel, then emit the next due level
    task automatic threshold_step(bit drain, logic [7:0] pix);
        int unsigned w, h, tw, th, ty, tx, tl, need, k, thr;
        int r, c, lo, hi, diff;
        logic [7:0] p;
        result_t res;
        w  = fit_size(p_width, MAX_W);
        h  = fit_size(p_height, MAX_H);
        tw = tiles_of(w);
        th = tiles_of(h);
        if (!drain && !frame_in && wr_col < w && wr_row < h) begin
            line_buf[(wr_row % LINE_RING)*MAX_W + wr_col] = pix;
            if (wr_col/TILE_SIDE < tw && wr_row/TILE_SIDE < th) begin
                k = ((wr_row/TILE_SIDE) % TILE_RING)*TILE_COLS + wr_col/TILE_SIDE;
                // first pixel of a tile opens it
                if (wr_row % TILE_SIDE == 0 && wr_col % TILE_SIDE == 0) begin
                    tile_lo_buf[k] = pix;
                    tile_hi_buf[k] = pix;
                end else begin
                    if (pix < tile_lo_buf[k]) tile_lo_buf[k] = pix;
                    if (pix > tile_hi_buf[k]) tile_hi_buf[k] = pix;
                end
            end
            wr_col++;
            if (wr_col >= w) begin
                wr_col = 0;
                wr_row++;
                if (wr_row >= h) begin
                    wr_row = 0;
                    frame_in = 1;
                end
            end
        end
        if (rd_col >= w || rd_row >= h) restart_positions();
        ty = (rd_row/TILE_SIDE >= th) ? th - 1 : rd_row/TILE_SIDE;
        tx = (rd_col/TILE_SIDE >= tw) ? tw - 1 : rd_col/TILE_SIDE;
        if (!frame_in) begin
            // all rows of the tile row below must be in
            tl   = (ty + 1 < th) ? ty + 1 : th - 1;
            need = tl*TILE_SIDE + TILE_SIDE - 1;
            if (need > h - 1) need = h - 1;
            if (rd_row > need) need = rd_row;
            if (wr_row <= need) return;
        end
        lo = 255;
        hi = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            r = int'(ty) + dy;
            if (r < 0) r = 0;
            if (r > int'(th) - 1) r = int'(th) - 1;
            for (int dx = -1; dx <= 1; dx++) begin
                c = int'(tx) + dx;
                if (c < 0) c = 0;
                if (c > int'(tw) - 1) c = int'(tw) - 1;
                k = (r % TILE_RING)*TILE_COLS + c;
                if (tile_lo_buf[k] < lo) lo = tile_lo_buf[k];
                if (tile_hi_buf[k] > hi) hi = tile_hi_buf[k];
            end
        end
        diff = (hi >= lo) ? hi - lo : 0;
        thr  = lo + diff/2;
        p    = line_buf[(rd_row % LINE_RING)*MAX_W + rd_col];
        if (diff < p_contrast) res.level = LEVEL_UNDECIDED;
        else res.level = (p > thr) ? LEVEL_WHITE : LEVEL_BLACK;
        res.frame_end = (rd_col == w - 1) && (rd_row == h - 1);
        levels_due.push_back(res);
        if (res.frame_end) begin
            restart_positions();
            frame_closed = 1;
        end else begin
            rd_col++;
            if (rd_col >= w) begin
                rd_col = 0;
                rd_row++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // driver: feeds pending items, holds off at random
    // ---------------------------------------------------------------
    px_item_t nxt;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (px_pending.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
                nxt = px_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.pix;
                s_tuser  <= nxt.drain ? FUNC_DRAIN : ~FUNC_DRAIN;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls at random
    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(0, 99) >= sink_stall);
    end

    // ---------------------------------------------------------------
    // monitor: checks results, then feeds the predictor with the transfer
    // ---------------------------------------------------------------
    result_t want;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (levels_due.size() == 0) begin
                    $display("%0t: unexpected result level=%0d frame_end=%0b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = levels_due.pop_front();
                    if (m_tdata !== want.level || m_tlast !== want.frame_end) begin
                        $display({"%0t: mismatch expected level=%0d frame_end=%0b,",
                                  " got level=%0d frame_end=%0b"},
                                 $time, want.level, want.frame_end, m_tdata, m_tlast);
                        errors++;
                    end
                end
            end
            // register write lands at the same edge as in the block
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_FRAME_WIDTH: begin
                        p_width = cfg_wr_data;
                        restart_positions();
                    end
                    CFG_FRAME_HEIGHT: begin
                        p_height = cfg_wr_data;
                        restart_positions();
                    end
                    CFG_MIN_CONTRAST: p_contrast = cfg_wr_data[CONTRAST_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) threshold_step(s_tuser == FUNC_DRAIN, s_tdata);
        end
    end

    // watchdog: no transfer for too long ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STUCK_CYC) begin
            $display("%0t: timeout, %0d results outstanding", $time, levels_due.size());
            $display("FAIL tile_minmax_adaptive_threshold_core");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic push_item(bit drain, logic [7:0] pix);
        px_item_t it;
        it.drain = drain;
        it.pix   = pix;
        px_pending.push_back(it);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // waits until every pending item is sent and every expected result is out, then the pipe empties
    task automatic wait_quiet();
        while (px_pending.size() > 0 || s_tvalid || levels_due.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        reg_write(CFG_FRAME_WIDTH, w);
        reg_write(CFG_FRAME_HEIGHT, h);
    endtask

    // drains until the frame_end result has been predicted
    task automatic flush_frame();
        while (!frame_closed) begin
            repeat (8) push_item(1'b1, 8'($urandom));
            while (px_pending.size() > 0) @(posedge aclk);
            @(posedge aclk);
        end
    endtask

    int unsigned n_pix = 0;
    int unsigned fw, fh, base, cut, phase;
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: one 4x4 tile of black/white, contrast off
        set_size(4, 4);
        reg_write(CFG_MIN_CONTRAST, 0);
        reg_write(CFG_SPARE_INDEX, 12'hfff);       // ignored register
        frame_closed = 0;
        for (int i = 0; i < 16; i++) begin
            push_item(1'b0, (i % 3 == 0) ? 8'd255 : 8'd0);
            if (i == 5) push_item(1'b1, 8'hff);        // drain mid-frame
        end
        push_item(1'b0, 8'h5a);                    // pixel after frame end acts as drain
        flush_frame();
        wait_quiet();
        // zero sizes clamp to one pixel, contrast above any difference
        set_size(0, 0);
        reg_write(CFG_MIN_CONTRAST, 256);
        frame_closed = 0;
        push_item(1'b0, 8'd255);
        flush_frame();
        wait_quiet();

        // random phases with all idle mixes
        for (phase = 0; n_pix < 550 || phase < 8; phase++) begin
            case (phase % 4)
                0: begin sender_idle = 0;  sink_stall = 0;  end
                1: begin sender_idle = 78; sink_stall = 0;  end
                2: begin sender_idle = 0;  sink_stall = 78; end
                default: begin sender_idle = 19; sink_stall = 19; end
            endcase
            if (phase == 3) begin
                fw = $urandom_range(40, 48); fh = $urandom_range(1, 3);    // wide rows
            end else if (phase == 7) begin
                fw = 1;    fh = $urandom_range(20, 40);                    // tall column
            end else begin
                fw = $urandom_range(1, 12);
                fh = $urandom_range(1, 8);
            end
            set_size(fw, fh);
            case ($urandom_range(0, 5))
                0: reg_write(CFG_MIN_CONTRAST, 0);
                1: reg_write(CFG_MIN_CONTRAST, 511);
                2: reg_write(CFG_MIN_CONTRAST, $urandom_range(0, 256));
                default: reg_write(CFG_MIN_CONTRAST, $urandom_range(0, 40));
            endcase
            fw = fit_size(fw, MAX_W);
            fh = fit_size(fh, MAX_H);
            for (int f = 0; f < 2; f++) begin
                frame_closed = 0;
                base = $urandom_range(0, 255);
                // some frames are cut short and abandoned by the next size write
                cut  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, fw*fh - 1) : fw*fh;
                for (int i = 0; i < cut; i++) begin
                    if ($urandom_range(0, 9) == 0) push_item(1'b1, 8'($urandom));
                    if ($urandom_range(0, 3) == 0) push_item(1'b0, 8'($urandom));
                    else push_item(1'b0, 8'(base ^ $urandom_range(0, 31)));
                    n_pix++;
                end
                if (cut < fw*fh) break;
                if ($urandom_range(0, 2) == 0) push_item(1'b0, 8'($urandom));
                flush_frame();
                wait_quiet();
            end
            wait_quiet();
        end
        reg_write(CFG_MIN_CONTRAST, CONTRAST_RESET);
        wait_quiet();

        if (errors == 0) begin
            $display("PASS tile_minmax_adaptive_threshold_core");
        end else begin
            $display("FAIL tile_minmax_adaptive_threshold_core");
        end
        $finish;
    end

endmodule
